/* sv/ipv4v_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Shared constants for the IPv4 address text validator.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

  localparam int unsigned ValueW   = 17;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned CountW   = 3;
  localparam int unsigned OctetW   = 8;
  localparam int unsigned PortW    = 16;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned DataW    = 32;

  // The value accumulator sticks here, just above any port limit.
  localparam logic [ValueW-1:0] FieldSat = 17'd65536;
  localparam logic [CountW-1:0] CountMax = 3'd7;

  localparam logic [OctetW-1:0] OctetLimitRst = 8'd255;
  localparam logic [PortW-1:0]  PortLimitRst  = 16'd65535;

  // Field positions: 0..3 are the dotted fields, 4 is the port.
  localparam logic [IndexW-1:0] IdxLastOctet = 3'd3;
  localparam logic [IndexW-1:0] IdxPort      = 3'd4;

  // Character codes.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;

  // Register indexes, taken from paddr[2].
  localparam logic RegOctetLimit = 1'b0;
  localparam logic RegPortLimit  = 1'b1;

endpackage

/* sv/ipv4_port_text_validator.sv */
// ----------------------------------------------------------------------------
// ipv4_port_text_validator
// Checks dotted-quad IPv4 text with an optional port, one character a beat.
// ----------------------------------------------------------------------------
// The input channel carries one character per beat with a flag on the last
// character of the text. The output channel carries one verdict beat per
// text, sent after its last character; other characters produce no beat.
// Every character updates the field state in the cycle it is accepted, so
// one character is taken per cycle while the input is ready. The verdict is
// in the output register in the cycle after the last character is accepted.
// The input stays ready while the verdict register is empty or is being
// drained in the same cycle; if the receiver stalls with a verdict pending,
// input is held off until that verdict is taken, since the next text may end
// in its first character.
// The APB port holds the octet limit at address 0 and the port limit at
// address 4; both limits are read when a number ends. Reset clears the text
// state and the verdict valid flag and restores both limits to their maximum.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ipv4_port_text_validator
  import ipv4v_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Character channel.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  // Verdict channel.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              address_ok_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [OctetW-1:0] octet_limit_q;
  logic [PortW-1:0]  port_limit_q;

  logic [IndexW-1:0] field_index_q, field_index_d;
  logic [ValueW-1:0] field_value_q, field_value_d;
  logic [CountW-1:0] digit_count_q, digit_count_d;
  logic              leading_zero_q, leading_zero_d;
  logic              error_seen_q, error_seen_d;
  logic              out_valid_q;
  logic              address_ok_q, address_ok_d;

  logic              in_fire;
  logic              cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_limit_q <= OctetLimitRst;
      port_limit_q  <= PortLimitRst;
    end else if (cfg_write) begin
      case (paddr[2])
        RegOctetLimit: octet_limit_q <= pwdata[OctetW-1:0];
        RegPortLimit:  port_limit_q  <= pwdata[PortW-1:0];
        default:       octet_limit_q <= octet_limit_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegOctetLimit: prdata = DataW'(octet_limit_q);
      RegPortLimit:  prdata = DataW'(port_limit_q);
      default:       prdata = '0;
    endcase
  end

  // Character update.
  logic              is_digit;
  logic [3:0]        digit;
  logic [20:0]       value_x10;
  logic              octet_ok;
  logic [IndexW-1:0] nxt_index;
  logic [ValueW-1:0] nxt_value;
  logic [CountW-1:0] nxt_count;
  logic              nxt_lzero;
  logic              nxt_error;
  logic              verdict;

  assign is_digit   = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign digit      = 4'(char_code_i - ChZero);
  assign value_x10  = (21'(field_value_q) << 3) + (21'(field_value_q) << 1) + 21'(digit);
  assign octet_ok   = (digit_count_q != '0) &&
                      (field_value_q <= ValueW'(octet_limit_q));

  always_comb begin
    nxt_index = field_index_q;
    nxt_value = field_value_q;
    nxt_count = digit_count_q;
    nxt_lzero = leading_zero_q;
    nxt_error = error_seen_q;
    if (is_digit) begin
      if (leading_zero_q) begin
        nxt_error = 1'b1;
      end
      if ((digit_count_q == '0) && (digit == 4'd0)) begin
        nxt_lzero = 1'b1;
      end
      nxt_value = (value_x10 > 21'(FieldSat)) ? FieldSat : value_x10[ValueW-1:0];
      if (digit_count_q < CountMax) begin
        nxt_count = digit_count_q + CountW'(1);
      end
    end else if (char_code_i == ChDot) begin
      if ((field_index_q < IdxLastOctet) && octet_ok) begin
        nxt_index = field_index_q + IndexW'(1);
        nxt_value = '0;
        nxt_count = '0;
        nxt_lzero = 1'b0;
      end else begin
        nxt_error = 1'b1;
      end
    end else if (char_code_i == ChColon) begin
      if ((field_index_q == IdxLastOctet) && octet_ok) begin
        nxt_index = IdxPort;
        nxt_value = '0;
        nxt_count = '0;
        nxt_lzero = 1'b0;
      end else begin
        nxt_error = 1'b1;
      end
    end else begin
      nxt_error = 1'b1;
    end

    // The verdict looks at the state after this character.
    if (nxt_index == IdxLastOctet) begin
      verdict = !nxt_error && (nxt_count != '0) &&
                (nxt_value <= ValueW'(octet_limit_q));
    end else if (nxt_index == IdxPort) begin
      verdict = !nxt_error && (nxt_count != '0) &&
                (nxt_value <= ValueW'(port_limit_q));
    end else begin
      verdict = 1'b0;
    end

    if (last_char_i) begin
      field_index_d  = '0;
      field_value_d  = '0;
      digit_count_d  = '0;
      leading_zero_d = 1'b0;
      error_seen_d   = 1'b0;
    end else begin
      field_index_d  = nxt_index;
      field_value_d  = nxt_value;
      digit_count_d  = nxt_count;
      leading_zero_d = nxt_lzero;
      error_seen_d   = nxt_error;
    end
    address_ok_d = verdict;
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q  <= '0;
      field_value_q  <= '0;
      digit_count_q  <= '0;
      leading_zero_q <= 1'b0;
      error_seen_q   <= 1'b0;
    end else if (in_fire) begin
      field_index_q  <= field_index_d;
      field_value_q  <= field_value_d;
      digit_count_q  <= digit_count_d;
      leading_zero_q <= leading_zero_d;
      error_seen_q   <= error_seen_d;
    end
  end

  // Verdict register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_char_i) begin
      address_ok_q <= address_ok_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign address_ok_o = address_ok_q;

  // Assertions.
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_char_i |=> out_valid_o)
    else $error("last character did not produce a verdict");

  a_last_clears_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_char_i |=> (field_index_q == '0) && !error_seen_q &&
                               (digit_count_q == '0) && !leading_zero_q)
    else $error("text state not cleared after last character");

  a_value_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_value_q <= FieldSat)
    else $error("field value above saturation point");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_index_q <= IdxPort)
    else $error("field index beyond the port field");

  a_no_verdict_midtext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last_char_i && !out_valid_o |=> !out_valid_o)
    else $error("verdict produced without a last character");

endmodule
